// ===== rtl/core/rspe_pkg.sv =====
// ----------------------------------------------------------------------------
// rspe_pkg
// Shared constants, types and GF(2^16) arithmetic for the RS parity encoder.
// ----------------------------------------------------------------------------
package rspe_pkg;

    localparam int SYM_W          = 16;
    localparam int PARITY_SYMBOLS = 6;
    localparam int COEFF_COUNT    = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int CNT_W          = $clog2(PARITY_SYMBOLS + 1);
    localparam int PROD_W         = 2 * SYM_W - 1;
    localparam int RED_N          = PROD_W - SYM_W;

    localparam logic [SYM_W:0] FIELD_POLY = 17'h103DD;

    typedef logic [SYM_W-1:0] sym_t;
    typedef logic [RED_N-1:0][SYM_W-1:0] red_tab_t;

    // Chain control: encode folds in the feedback, drain shifts parity out
    typedef struct packed {
        logic encode;
        logic drain;
    } cell_ctrl_t;

    // x^(16+k) mod field polynomial, k = 0 .. 14
    function automatic red_tab_t gf_red_table();
        red_tab_t        tab;
        logic [SYM_W:0]  x;
        tab = '0;
        x = {{SYM_W{1'b0}}, 1'b1};
        for (int k = 0; k < PROD_W; k++)
        begin
            if (k >= SYM_W)
                tab[k-SYM_W] = x[SYM_W-1:0];
            x = x << 1;
            if (x[SYM_W])
                x = x ^ FIELD_POLY;
        end
        return tab;
    endfunction

    localparam red_tab_t GF_RED = gf_red_table();

    // Carry-less product, then fold the high bits back with fixed residues
    function automatic sym_t gf_mul(input sym_t a, input sym_t b);
        logic [PROD_W-1:0] prod;
        sym_t              res;
        prod = '0;
        for (int j = 0; j < SYM_W; j++)
        begin
            if (b[j])
                prod = prod ^ ({{(PROD_W-SYM_W){1'b0}}, a} << j);
        end
        res = prod[SYM_W-1:0];
        for (int k = 0; k < RED_N; k++)
        begin
            if (prod[SYM_W+k])
                res = res ^ GF_RED[k];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/rspe_cell.sv =====
// ----------------------------------------------------------------------------
// rspe_cell
// One stage of the parity divider: holds one remainder coefficient.
// ----------------------------------------------------------------------------
module rspe_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  rspe_pkg::cell_ctrl_t ctrl,
    input  rspe_pkg::sym_t      prev,
    input  rspe_pkg::sym_t      feedback,
    input  rspe_pkg::sym_t      coeff,
    output rspe_pkg::sym_t      q
);
    import rspe_pkg::*;

    sym_t q_reg;
    sym_t q_next;

    always_comb
    begin
        q_next = q_reg;
        if (ctrl.encode)
            q_next = prev ^ gf_mul(feedback, coeff);
        else if (ctrl.drain)
            q_next = prev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_reg <= '0;
        else
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== rtl/core/reed_solomon_parity_encoder.sv =====
// A message symbol is captured in the output register on its input transfer.
// Throughput: one message symbol per cycle while the output is free; the final
// symbol of a codeword is followed by PARITY_SYMBOLS parity transfers, one per
// cycle while the output is free, during which input is held off.
// Reset clears the remainder chain, the generator coefficients and the output valid.
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder
// Systematic RS encoder over GF(2^16): passthrough plus chained parity cells.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rspe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rspe_pkg::SYM_W-1:0]      cfg_data,
    // message input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rspe_pkg::SYM_W-1:0]      s_tdata,   // [15:0] symbol
    input  logic                            s_tlast,   // final_symbol
    // codeword output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rspe_pkg::SYM_W-1:0]      m_tdata,   // [15:0] code_symbol
    output logic                            m_tuser,   // [0] is_parity
    output logic                            m_tlast    // end_of_codeword
);
    import rspe_pkg::*;

    sym_t coeff_reg [COEFF_COUNT];

    sym_t             cell_q [PARITY_SYMBOLS];
    sym_t             feedback;
    cell_ctrl_t       ctrl;

    logic             out_valid_reg;
    sym_t             out_sym_reg;
    logic             out_par_reg;
    logic             out_end_reg;
    logic [CNT_W-1:0] drain_cnt_reg;
    logic [CNT_W-1:0] drain_cnt_next;

    logic out_free;
    logic in_xfer;
    logic draining;
    logic drain_step;

    // coefficient registers; indices beyond the list fall through
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEFF_COUNT; i++)
                coeff_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < COEFF_COUNT; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                    coeff_reg[i] <= cfg_data;
            end
        end
    end

    assign out_free   = !out_valid_reg || m_tready;
    assign draining   = (drain_cnt_reg != '0);
    assign s_tready   = out_free && !draining;
    assign in_xfer    = s_tvalid && s_tready;
    assign drain_step = draining && out_free;

    assign feedback    = s_tdata ^ cell_q[PARITY_SYMBOLS-1];
    assign ctrl.encode = in_xfer;
    assign ctrl.drain  = drain_step;

    for (genvar g = 0; g < PARITY_SYMBOLS; g++)
    begin : g_cell
        sym_t prev;
        if (g == 0)
        begin : g_head
            assign prev = '0;
        end
        else
        begin : g_link
            assign prev = cell_q[g-1];
        end

        rspe_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .prev     (prev),
            .feedback (feedback),
            .coeff    (coeff_reg[g]),
            .q        (cell_q[g])
        );
    end

    always_comb
    begin
        drain_cnt_next = drain_cnt_reg;
        if (in_xfer && s_tlast)
            drain_cnt_next = CNT_W'(PARITY_SYMBOLS);
        else if (drain_step)
            drain_cnt_next = drain_cnt_reg - 1'b1;
    end

    // output register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            drain_cnt_reg <= '0;
        end
        else
        begin
            drain_cnt_reg <= drain_cnt_next;
            if (in_xfer || drain_step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // output register: payload; parity leaves from the top cell
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_sym_reg <= s_tdata;
            out_par_reg <= 1'b0;
            out_end_reg <= 1'b0;
        end
        else if (drain_step)
        begin
            out_sym_reg <= cell_q[PARITY_SYMBOLS-1];
            out_par_reg <= 1'b1;
            out_end_reg <= (drain_cnt_reg == CNT_W'(1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tuser  = out_par_reg;
    assign m_tlast  = out_end_reg;

endmodule

// ===== verif/reed_solomon_parity_encoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder_tb
// Drives message symbols through the encoder and checks every passthrough and
// parity transfer against a GF(2^16) long-division predictor. Coefficients
// are reloaded between phases: zeros, the usual roots-of-0x43 generator, all
// ones and random values. A long output hold-off is applied to force input
// back-pressure.
// ----------------------------------------------------------------------------
module reed_solomon_parity_encoder_tb;

    import rspe_pkg::SYM_W;
    import rspe_pkg::PARITY_SYMBOLS;
    import rspe_pkg::COEFF_COUNT;
    import rspe_pkg::CFG_IDX_W;
    import rspe_pkg::FIELD_POLY;

    localparam int CLK_PERIOD  = 12;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 80;
    localparam int PRINT_CAP   = 50;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_GEN_C0,
        REG_GEN_C1,
        REG_GEN_C2,
        REG_GEN_C3,
        REG_GEN_C4,
        REG_GEN_C5,
        REG_SPARE_6,
        REG_SPARE_7
    } cfg_reg_e;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             final_symbol;
    } msg_item_t;

    typedef struct packed {
        logic [SYM_W-1:0] code_symbol;
        logic             is_parity;
        logic             end_of_codeword;
    } code_item_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SYM_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [SYM_W-1:0]     s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [SYM_W-1:0]     m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // Predictor state
    logic [SYM_W-1:0] gen_coeff [COEFF_COUNT];
    logic [SYM_W-1:0] remainder [PARITY_SYMBOLS];
    logic [SYM_W-1:0] next_gen  [COEFF_COUNT];

    msg_item_t  message_q  [$];
    code_item_t codeword_q [$];

    logic s_taken   = 1'b0;
    logic cfg_taken = 1'b0;
    bit   calm      = 1'b0;
    int   queued_symbols   = 0;
    int   accepted_symbols = 0;
    int   send_gap    = 0;
    int   stall_left  = 0;
    int   hold_left   = 0;
    int   hold_reqs   = 0;
    int   hold_served = 0;
    int   mismatches  = 0;
    int   cycle_count = 0;

    reed_solomon_parity_encoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [15:0] symbol
        .s_tlast   (s_tlast),    // final_symbol
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [15:0] code_symbol
        .m_tuser   (m_tuser),    // [0] is_parity
        .m_tlast   (m_tlast)     // end_of_codeword
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Shift-and-reduce field multiply
    function automatic logic [SYM_W-1:0] field_product(input logic [SYM_W-1:0] a,
                                                       input logic [SYM_W-1:0] b);
        logic [SYM_W:0]   x;
        logic [SYM_W-1:0] acc;
        acc = '0;
        x   = {1'b0, a};
        for (int k = 0; k < SYM_W; k++)
        begin
            if (b[k])
                acc = acc ^ x[SYM_W-1:0];
            x = x << 1;
            if (x[SYM_W])
                x = x ^ FIELD_POLY;
        end
        return acc;
    endfunction

    // One division step; on the final symbol the remainder is drained
    task automatic encode_symbol(input logic [SYM_W-1:0] sym, input logic last);
        logic [SYM_W-1:0] fb;
        fb = sym ^ remainder[PARITY_SYMBOLS-1];
        for (int i = PARITY_SYMBOLS - 1; i > 0; i--)
            remainder[i] = remainder[i-1] ^ field_product(fb, gen_coeff[i]);
        remainder[0] = field_product(fb, gen_coeff[0]);
        codeword_q.push_back('{code_symbol: sym, is_parity: 1'b0, end_of_codeword: 1'b0});
        if (last)
        begin
            for (int i = PARITY_SYMBOLS - 1; i >= 0; i--)
                codeword_q.push_back('{code_symbol: remainder[i], is_parity: 1'b1,
                                       end_of_codeword: (i == 0)});
            for (int i = 0; i < PARITY_SYMBOLS; i++)
                remainder[i] = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [SYM_W-1:0] got,
                                   input logic [SYM_W-1:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch, %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Sampling, prediction and checking at the rising edge
    always @(posedge clk)
    begin
        code_item_t want;
        cfg_taken <= cfg_valid && cfg_ready;
        s_taken   <= s_tvalid && s_tready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready && cfg_index < COEFF_COUNT)
                gen_coeff[cfg_index] = cfg_data;
            if (s_tvalid && s_tready)
            begin
                accepted_symbols++;
                encode_symbol(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                if (codeword_q.size() == 0)
                    report_mismatch("transfer with nothing pending", m_tdata, '0);
                else
                begin
                    want = codeword_q.pop_front();
                    if (m_tdata !== want.code_symbol)
                        report_mismatch("code_symbol", m_tdata, want.code_symbol);
                    if (m_tuser !== want.is_parity)
                        report_mismatch("is_parity", SYM_W'(m_tuser),
                                        SYM_W'(want.is_parity));
                    if (m_tlast !== want.end_of_codeword)
                        report_mismatch("end_of_codeword", SYM_W'(m_tlast),
                                        SYM_W'(want.end_of_codeword));
                end
            end
        end
    end

    // Message driver
    always @(negedge clk)
    begin
        msg_item_t nxt;
        if (rst_n && (!s_tvalid || s_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (!calm && message_q.size() != 0 && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 6);
                s_tvalid <= 1'b0;
            end
            else if (message_q.size() != 0)
            begin
                nxt = message_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.symbol;
                s_tlast  <= nxt.final_symbol;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Codeword receiver: random stalls plus the occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_served != hold_reqs)
        begin
            hold_left = HOLD_CYCLES;
            hold_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** reed_solomon_parity_encoder: FAILED **");
            $finish;
        end
    end

    task automatic push_symbol(input logic [SYM_W-1:0] sym, input logic last);
        message_q.push_back('{symbol: sym, final_symbol: last});
        queued_symbols++;
    endtask

    function automatic logic [SYM_W-1:0] random_symbol();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return SYM_W'($urandom);
        endcase
    endfunction

    // Whole codewords of random content, mostly short
    task automatic random_codewords(input int target);
        int n;
        int len;
        n = 0;
        while (n < target)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                push_symbol(random_symbol(), i == len - 1);
            n += len;
        end
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [SYM_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_generator();
        for (int i = 0; i < COEFF_COUNT; i++)
            write_reg(cfg_reg_e'(i), next_gen[i]);
    endtask

    // Every queued symbol taken and every expected transfer seen
    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_symbols != queued_symbols || codeword_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [SYM_W-1:0] root;
        logic [SYM_W-1:0] std_gen [PARITY_SYMBOLS+1];
        for (int i = 0; i < COEFF_COUNT; i++)
            gen_coeff[i] = '0;
        for (int i = 0; i < PARITY_SYMBOLS; i++)
            remainder[i] = '0;

        // g(x) = prod (x + 0x43^i), i = 1 .. PARITY_SYMBOLS
        std_gen[0] = 16'h0001;
        for (int d = 1; d <= PARITY_SYMBOLS; d++)
            std_gen[d] = '0;
        root = 16'h0001;
        for (int i = 1; i <= PARITY_SYMBOLS; i++)
        begin
            root = field_product(root, 16'h0043);
            for (int d = PARITY_SYMBOLS; d > 0; d--)
                std_gen[d] = std_gen[d-1] ^ field_product(std_gen[d], root);
            std_gen[0] = field_product(std_gen[0], root);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Coefficients still at reset: parity comes out zero
        push_symbol(16'hFFFF, 1'b1);
        push_symbol(16'h1234, 1'b0);
        push_symbol(16'h0000, 1'b1);
        wait_drained();

        // Usual generator; writes to spare indices must change nothing
        for (int i = 0; i < COEFF_COUNT; i++)
            next_gen[i] = std_gen[i];
        load_generator();
        write_reg(REG_SPARE_6, 16'hFFFF);
        write_reg(REG_SPARE_7, 16'hFFFF);
        push_symbol(16'h0001, 1'b1);
        push_symbol(16'h8000, 1'b1);
        push_symbol(16'hFFFF, 1'b1);
        push_symbol(16'h0000, 1'b0);
        push_symbol(16'hFFFF, 1'b0);
        push_symbol(16'h0001, 1'b0);
        push_symbol(16'hAAAA, 1'b1);
        push_symbol(16'h0000, 1'b1);
        wait_drained();

        // All-ones coefficients; phase ends part way through a codeword
        for (int i = 0; i < COEFF_COUNT; i++)
            next_gen[i] = '1;
        load_generator();
        push_symbol(16'hFFFF, 1'b0);
        push_symbol(16'h5555, 1'b0);
        push_symbol(16'hFFFF, 1'b1);
        random_codewords(35);
        push_symbol(random_symbol(), 1'b0);
        push_symbol(random_symbol(), 1'b0);
        push_symbol(random_symbol(), 1'b0);
        wait_drained();

        // Random coefficients loaded mid-codeword, then a long output hold-off
        for (int i = 0; i < COEFF_COUNT; i++)
            next_gen[i] = SYM_W'($urandom);
        load_generator();
        write_reg(REG_SPARE_6, SYM_W'($urandom));
        write_reg(REG_SPARE_7, SYM_W'($urandom));
        push_symbol(random_symbol(), 1'b1);
        hold_reqs++;
        random_codewords(55);
        wait_drained();

        // Usual generator again, no idling on either side
        calm = 1'b1;
        for (int i = 0; i < COEFF_COUNT; i++)
            next_gen[i] = std_gen[i];
        load_generator();
        random_codewords(40);
        wait_drained();
        repeat (20) @(negedge clk);

        if (mismatches == 0)
            $display("** reed_solomon_parity_encoder: PASSED **");
        else
            $display("** reed_solomon_parity_encoder: FAILED **");
        $finish;
    end

endmodule
